// ===== sv/ihwl_pkg.sv =====
// shared types, constants and helpers for the hex word loader
package ihwl_pkg;

   localparam int DEF_DATA_BITS     = 14;
   localparam int DEF_MAX_ADDR_BITS = 15;
   localparam int DEF_QUEUE_DEPTH   = 4;

   localparam int CHAR_BITS      = 8;
   localparam int ADDR_OUT_BITS  = 15;
   localparam int DATA_OUT_BITS  = 14;
   localparam int EVENT_BITS     = 16;
   localparam int ADDR_CFG_BITS  = 4;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [ADDR_CFG_BITS-1:0] ADDR_WIDTH_RESET = 4'd13;
   localparam logic CSR_IDX_ADDR_WIDTH = 1'b0;

   localparam logic [CHAR_BITS-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CHAR_COLON = 8'h3A;

   typedef struct packed {
      logic                  stop;
      logic [EVENT_BITS-1:0] addr;
      logic [EVENT_BITS-1:0] data;
   } ihwl_event_type;

   typedef struct packed {
      logic           valid;
      ihwl_event_type ev;
   } ihwl_push_type;

   function automatic logic [3:0] hex_nibble(input logic [CHAR_BITS-1:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         n = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         n = 4'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         n = 4'(c - 8'h61 + 8'd10);
      end
      return n;
   endfunction

endpackage

// ===== sv/ihwl_req_if.sv =====
// request channel: one text character per request
interface ihwl_req_if;
   logic                           valid;
   logic                           ready;
   logic [ihwl_pkg::CHAR_BITS-1:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

// ===== sv/ihwl_rsp_if.sv =====
// response channel: one loaded word or the stop marker
interface ihwl_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ihwl_pkg::ADDR_OUT_BITS-1:0] word_addr;
   logic [ihwl_pkg::DATA_OUT_BITS-1:0] word_data;
   logic                               finished;

   modport source (output valid, output word_addr, output word_data, output finished,
                   input ready);
   modport sink (input valid, input word_addr, input word_data, input finished,
                 output ready);
endinterface

// ===== sv/intel_hex_word_loader.sv =====
// top level of the hex word loader: csr port, parser, queue and response stage
// an event from an accepted request is stored in the queue, then loaded into the response register for rsp valid
// throughput: one character per cycle while the queue is not full; the parser state updates on each accepted character
// the response register and queue let the parser keep taking requests while rsp stalls, until the queue fills
// reset (synchronous): parser to line start, queue and response emptied
// reset also sets addr_width to 13
module intel_hex_word_loader #(
   parameter int DATA_BITS     = ihwl_pkg::DEF_DATA_BITS,
   parameter int MAX_ADDR_BITS = ihwl_pkg::DEF_MAX_ADDR_BITS,
   parameter int QUEUE_DEPTH   = ihwl_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   ihwl_req_if.sink                            req_chan,
   ihwl_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ihwl_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [ihwl_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [ihwl_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   logic [ihwl_pkg::ADDR_CFG_BITS-1:0] addr_width_ff, addr_width_in;
   logic                               csr_hit;

   ihwl_pkg::ihwl_push_type  push;
   ihwl_pkg::ihwl_event_type head;
   logic                     queue_full;
   logic                     head_valid;
   logic                     pop;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[ihwl_pkg::CSR_ADDR_BITS-1] == ihwl_pkg::CSR_IDX_ADDR_WIDTH);
   assign csr_prdata = csr_hit ? ihwl_pkg::CSR_DATA_BITS'(addr_width_ff) : '0;

   always_comb begin
      addr_width_in = addr_width_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         addr_width_in = csr_pwdata[ihwl_pkg::ADDR_CFG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_width_ff <= ihwl_pkg::ADDR_WIDTH_RESET;
      end else begin
         addr_width_ff <= addr_width_in;
      end
   end

   ihwl_front #(
      .MAX_ADDR_BITS (MAX_ADDR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   ihwl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   ihwl_back #(
      .DATA_BITS     (DATA_BITS),
      .MAX_ADDR_BITS (MAX_ADDR_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .addr_width (addr_width_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== sv/ihwl_front.sv =====
// record parser: takes characters and queues word and stop events
module ihwl_front #(
   parameter int MAX_ADDR_BITS = ihwl_pkg::DEF_MAX_ADDR_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   ihwl_req_if.sink                req_chan,
   input  logic                    queue_full,
   output ihwl_pkg::ihwl_push_type push
);

   localparam logic [2:0] PH_LINE  = 3'd0;
   localparam logic [2:0] PH_COUNT = 3'd1;
   localparam logic [2:0] PH_ADDR  = 3'd2;
   localparam logic [2:0] PH_TYPE  = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;
   localparam logic [2:0] PH_CSUM  = 3'd5;

   logic [2:0]               phase_ff, phase_in;
   logic [1:0]               digit_count_ff, digit_count_in;
   logic [15:0]              byte_accum_ff, byte_accum_in;
   logic [7:0]               low_byte_ff, low_byte_in;
   logic [6:0]               words_left_ff, words_left_in;
   logic [MAX_ADDR_BITS-1:0] cur_addr_ff, cur_addr_in;
   logic                     stopped_ff, stopped_in;

   logic        accept;
   logic        in_record;
   logic [15:0] acc_shift;
   logic [1:0]  last_digit;
   logic [6:0]  words_dec;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      in_record  = (phase_ff >= PH_COUNT) && (phase_ff <= PH_CSUM);
      acc_shift  = {byte_accum_ff[11:0], ihwl_pkg::hex_nibble(req_chan.char_in)};
      last_digit = (phase_ff == PH_ADDR || phase_ff == PH_DATA) ? 2'd3 : 2'd1;
      words_dec  = words_left_ff - 7'd1;

      phase_in       = phase_ff;
      digit_count_in = digit_count_ff;
      byte_accum_in  = byte_accum_ff;
      low_byte_in    = low_byte_ff;
      words_left_in  = words_left_ff;
      cur_addr_in    = cur_addr_ff;
      stopped_in     = stopped_ff;
      push           = '0;

      if (accept && !stopped_ff) begin
         if (!in_record) begin
            phase_in = PH_LINE;
            if (req_chan.char_in == ihwl_pkg::CHAR_LF || req_chan.char_in == ihwl_pkg::CHAR_CR) begin
               phase_in = PH_LINE;
            end else if (req_chan.char_in == ihwl_pkg::CHAR_COLON) begin
               phase_in       = PH_COUNT;
               digit_count_in = 2'd0;
               byte_accum_in  = 16'd0;
            end else begin
               stopped_in    = 1'b1;
               push.valid    = 1'b1;
               push.ev.stop  = 1'b1;
            end
         end else if (digit_count_ff != last_digit) begin
            byte_accum_in  = acc_shift;
            digit_count_in = digit_count_ff + 2'd1;
            if (phase_ff == PH_DATA && digit_count_ff == 2'd1) begin
               low_byte_in = acc_shift[7:0];
            end
         end else begin
            digit_count_in = 2'd0;
            byte_accum_in  = 16'd0;
            unique case (phase_ff)
               PH_COUNT: begin
                  words_left_in = acc_shift[7:1];
                  phase_in      = PH_ADDR;
               end
               PH_ADDR: begin
                  cur_addr_in = MAX_ADDR_BITS'({1'b0, acc_shift[15:1]});
                  phase_in    = PH_TYPE;
               end
               PH_TYPE: begin
                  phase_in = (words_left_ff != 7'd0) ? PH_DATA : PH_CSUM;
               end
               PH_DATA: begin
                  push.valid    = 1'b1;
                  push.ev.addr  = ihwl_pkg::EVENT_BITS'(cur_addr_ff);
                  push.ev.data  = {acc_shift[7:0], low_byte_ff};
                  cur_addr_in   = cur_addr_ff + MAX_ADDR_BITS'(1);
                  words_left_in = words_dec;
                  phase_in      = (words_dec != 7'd0) ? PH_DATA : PH_CSUM;
               end
               default: begin
                  phase_in = PH_LINE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LINE;
         digit_count_ff <= 2'd0;
         byte_accum_ff  <= 16'd0;
         low_byte_ff    <= 8'd0;
         words_left_ff  <= 7'd0;
         cur_addr_ff    <= '0;
         stopped_ff     <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         digit_count_ff <= digit_count_in;
         byte_accum_ff  <= byte_accum_in;
         low_byte_ff    <= low_byte_in;
         words_left_ff  <= words_left_in;
         cur_addr_ff    <= cur_addr_in;
         stopped_ff     <= stopped_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) stopped_ff |=> stopped_ff)
      else $error("loader left the stopped state");

   assert property (@(posedge clock) disable iff (reset) push.valid |-> accept && !stopped_ff)
      else $error("event pushed without an accepted request");

endmodule

// ===== sv/ihwl_queue.sv =====
// short event queue between the parser and the response stage
module ihwl_queue #(
   parameter int DEPTH = ihwl_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ihwl_pkg::ihwl_push_type  push,
   output logic                     full,
   output logic                     head_valid,
   output ihwl_pkg::ihwl_event_type head,
   input  logic                     pop
);

   localparam int PtrBits   = $clog2(DEPTH);
   localparam int CountBits = $clog2(DEPTH + 1);
   localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);

   ihwl_pkg::ihwl_event_type store_ff [DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == CountBits'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = store_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CountBits'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CountBits'(DEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset) !(push.valid && full))
      else $error("event pushed into a full queue");

endmodule

// ===== sv/ihwl_back.sv =====
// response stage: masks the queued event and holds it for the sink
module ihwl_back #(
   parameter int DATA_BITS     = ihwl_pkg::DEF_DATA_BITS,
   parameter int MAX_ADDR_BITS = ihwl_pkg::DEF_MAX_ADDR_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [ihwl_pkg::ADDR_CFG_BITS-1:0]   addr_width,
   input  logic                                 head_valid,
   input  ihwl_pkg::ihwl_event_type             head,
   output logic                                 pop,
   ihwl_rsp_if.source                           rsp_chan
);

   localparam int EvBits = ihwl_pkg::EVENT_BITS;
   localparam logic [4:0] MaxAddrBitsW = 5'(MAX_ADDR_BITS);
   localparam logic [EvBits:0] DataMaskWide = ((EvBits + 1)'(1) << DATA_BITS) - (EvBits + 1)'(1);

   logic                                 valid_ff, valid_in;
   logic [ihwl_pkg::ADDR_OUT_BITS-1:0]   word_addr_ff, word_addr_in;
   logic [ihwl_pkg::DATA_OUT_BITS-1:0]   word_data_ff, word_data_in;
   logic                                 finished_ff, finished_in;

   logic [4:0]        width_eff;
   logic [EvBits:0]   addr_mask;
   logic [EvBits-1:0] masked_addr;
   logic [EvBits-1:0] masked_data;

   assign pop = head_valid && (!valid_ff || rsp_chan.ready);

   always_comb begin
      width_eff   = ({1'b0, addr_width} > MaxAddrBitsW) ? MaxAddrBitsW : {1'b0, addr_width};
      addr_mask   = ((EvBits + 1)'(1) << width_eff) - (EvBits + 1)'(1);
      masked_addr = head.addr & addr_mask[EvBits-1:0];
      masked_data = head.data & DataMaskWide[EvBits-1:0];

      valid_in     = valid_ff;
      word_addr_in = word_addr_ff;
      word_data_in = word_data_ff;
      finished_in  = finished_ff;
      if (pop) begin
         valid_in     = 1'b1;
         word_addr_in = masked_addr[ihwl_pkg::ADDR_OUT_BITS-1:0];
         word_data_in = masked_data[ihwl_pkg::DATA_OUT_BITS-1:0];
         finished_in  = head.stop;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_addr_ff <= word_addr_in;
      word_data_ff <= word_data_in;
      finished_ff  <= finished_in;
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.word_addr = word_addr_ff;
   assign rsp_chan.word_data = word_data_ff;
   assign rsp_chan.finished  = finished_ff;

   assert property (@(posedge clock) disable iff (reset)
      valid_ff && finished_ff |-> word_addr_ff == '0 && word_data_ff == '0)
      else $error("stop response carries a nonzero word");

endmodule
